/* rtl/bdq_pkg.sv */
// shared types and codes for the bounded deque with read cursor
// item and result structs, command and status codes, default sizes
`timescale 1ns / 1ps

package bdq_pkg;

	localparam int DEPTH_DEF      = 256;
	localparam int ITEM_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_READ_AT    = 3'd3,
		CMD_REWIND     = 3'd4,
		CMD_READ_NEXT  = 3'd5
	} bdq_cmd_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_FULL  = 3'd1,
		ST_EMPTY = 3'd2,
		ST_RANGE = 3'd3,
		ST_END   = 3'd4
	} bdq_status_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] item_in;
		logic [7:0]  position;
	} bdq_req_t;

	typedef struct packed {
		logic [31:0] item_out;
		logic [2:0]  status;
		logic [8:0]  count;
	} bdq_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic exec;
		logic show;
	} bdq_ctl_t;

endpackage

/* rtl/bdq_ctrl.sv */
// controller for the deque: accepts a command, then presents its result
// depends on bdq_pkg
`timescale 1ns / 1ps

module bdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output bdq_pkg::bdq_ctl_t ctl
);
	import bdq_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_RESP
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RESP;
						busy_q  <= 1'b1;
						done_q  <= 1'b1;
					end
				end
				S_RESP: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign ctl.exec = start && (state_q == S_IDLE);
	assign ctl.show = done_q;

endmodule

/* rtl/bdq_datapath.sv */
// deque datapath: ring pointers, cursor, slot memory and result registers
// depends on bdq_pkg
`timescale 1ns / 1ps

module bdq_datapath #(
	parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
	parameter int ITEM_WIDTH = bdq_pkg::ITEM_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bdq_pkg::bdq_ctl_t ctl,
	input  bdq_pkg::bdq_req_t req,
	output bdq_pkg::bdq_rsp_t rsp
);
	import bdq_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
	localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	// head plus an offset below DEPTH, wrapped once
	function automatic logic [IDX_W-1:0] ring_at(input logic [IDX_W-1:0] base,
	                                             input logic [IDX_W-1:0] off);
		logic [IDX_W:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= DEPTH_X)
			s = s - DEPTH_X;
		return s[IDX_W-1:0];
	endfunction

	logic [ITEM_WIDTH-1:0] slots [DEPTH];

	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] coff_q;
	logic             live_q;

	logic [IDX_W-1:0] head_n;
	logic [CNT_W-1:0] cnt_n;
	logic [CNT_W-1:0] coff_n;
	logic             live_n;

	logic             we;
	logic             re;
	logic [IDX_W-1:0] waddr;
	logic [IDX_W-1:0] raddr;
	bdq_status_t      st;

	logic [ITEM_WIDTH-1:0] rdata_s1;
	bdq_status_t           st_s1;
	logic                  hit_s1;

	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic [CNT_W:0]   coff_inc;

	always_comb begin
		head_n   = head_q;
		cnt_n    = cnt_q;
		coff_n   = coff_q;
		live_n   = live_q;
		we       = 1'b0;
		re       = 1'b0;
		waddr    = head_q;
		raddr    = head_q;
		st       = ST_OK;
		pos_x    = CMP_W'(req.position);
		cnt_x    = CMP_W'(cnt_q);
		coff_inc = {1'b0, coff_q} + (CNT_W + 1)'(1);
		case (bdq_cmd_t'(req.cmd))
			CMD_PUSH_FRONT: begin
				if (cnt_q == FULL_CNT) begin
					st = ST_FULL;
				end else begin
					head_n = (head_q == '0) ? LAST_IDX : head_q - IDX_W'(1);
					we     = 1'b1;
					waddr  = head_n;
					cnt_n  = cnt_q + CNT_W'(1);
					if (live_q)
						coff_n = coff_inc[CNT_W-1:0];
				end
			end
			CMD_PUSH_BACK: begin
				if (cnt_q == FULL_CNT) begin
					st = ST_FULL;
				end else begin
					we    = 1'b1;
					waddr = ring_at(head_q, cnt_q[IDX_W-1:0]);
					cnt_n = cnt_q + CNT_W'(1);
				end
			end
			CMD_POP_FRONT: begin
				if (cnt_q == '0) begin
					st = ST_EMPTY;
				end else begin
					re     = 1'b1;
					raddr  = head_q;
					head_n = (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
					cnt_n  = cnt_q - CNT_W'(1);
					if (live_q) begin
						if (coff_q != '0)
							coff_n = coff_q - CNT_W'(1);
						if (cnt_q == CNT_W'(1)) begin
							live_n = 1'b0;
							coff_n = '0;
						end
					end
				end
			end
			CMD_READ_AT: begin
				if (pos_x >= cnt_x) begin
					st = ST_RANGE;
				end else begin
					re     = 1'b1;
					raddr  = ring_at(head_q, IDX_W'(req.position));
					coff_n = CNT_W'(req.position);
					live_n = 1'b1;
				end
			end
			CMD_REWIND: begin
				coff_n = '0;
				live_n = (cnt_q != '0);
			end
			CMD_READ_NEXT: begin
				if (!live_q || (coff_q >= cnt_q)) begin
					live_n = 1'b0;
					st     = ST_END;
				end else begin
					re     = 1'b1;
					raddr  = ring_at(head_q, coff_q[IDX_W-1:0]);
					coff_n = coff_inc[CNT_W-1:0];
					if (coff_inc >= {1'b0, cnt_q})
						live_n = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
			coff_q <= '0;
			live_q <= 1'b0;
		end else if (ctl.exec) begin
			head_q <= head_n;
			cnt_q  <= cnt_n;
			coff_q <= coff_n;
			live_q <= live_n;
		end
	end

	// slot memory, one write or one registered read per command
	always_ff @(posedge clk) begin
		if (ctl.exec && we)
			slots[waddr] <= ITEM_WIDTH'(req.item_in);
	end

	always_ff @(posedge clk) begin
		if (ctl.exec && re)
			rdata_s1 <= slots[raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			st_s1  <= st;
			hit_s1 <= re;
		end
	end

	assign rsp.item_out = (ctl.show && hit_s1) ? 32'(rdata_s1) : 32'd0;
	assign rsp.status   = ctl.show ? st_s1 : ST_OK;
	assign rsp.count    = 9'(cnt_q);

endmodule

/* rtl/bounded_deque_with_cursor_unit.sv */
// top level of the bounded deque with read cursor
// joins bdq_ctrl and bdq_datapath; depends on bdq_pkg
`timescale 1ns / 1ps

// channel   ports            handshake                    payload
// command   start, busy      taken when start && !busy    req (cmd, item_in, position)
// result    done             one cycle, cannot be held    rsp (item_out, status, count)
//
// each command is accepted at one edge, and its result is shown in the
// following cycle while busy is high; the registered read of the slot
// memory is why the result waits for that cycle
// reset clears head, count and cursor; the slot memory is not cleared
// the receiver cannot stall, so done lasts exactly one cycle per item
// busy falls again with done, and a new item may be taken at the next edge

module bounded_deque_with_cursor_unit #(
	parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
	parameter int ITEM_WIDTH = bdq_pkg::ITEM_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bdq_pkg::bdq_req_t req,
	output logic              done,
	output bdq_pkg::bdq_rsp_t rsp
);
	import bdq_pkg::*;

	// execute and present strobes toward the datapath
	bdq_ctl_t ctl;

	bdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	// ring pointers, cursor and slot memory
	bdq_datapath #(
		.DEPTH      (DEPTH),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

/* tb/bounded_deque_with_cursor_unit_test.sv */
// self-checking bench for bounded_deque_with_cursor_unit: a directed table, then random commands
// a behavioral mirror of the ring store predicts every result but those of pinned rows; depends on bdq_pkg
`timescale 1ns / 1ps

module bounded_deque_with_cursor_unit_test;
	import bdq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 650;

	// codes outside the command set, the block must ignore them
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	// one row of the directed table; pinned rows carry their result typed in
	typedef struct {
		bdq_req_t req;
		logic     pinned;
		bdq_rsp_t want;
	} stim_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	bdq_req_t req = '0;
	logic     done;
	bdq_rsp_t rsp;

	// mirror of the deque: ring store, front index, fill level, read cursor
	logic [31:0] mirror_slot [0:DEPTH-1];
	logic [7:0]  mirror_head = '0;
	logic [8:0]  mirror_count = '0;
	logic [8:0]  mirror_cur_ofs = '0;
	logic        mirror_cur_live = 1'b0;

	// results still owed by the block, oldest first
	bdq_rsp_t awaited_results [$];

	int fault_count = 0;
	int sender_idle_pct = 7;

	stim_row_t plan [25];

	bounded_deque_with_cursor_unit u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// apply one command to the mirror and return the result it owes
	function automatic bdq_rsp_t deque_outcome(input bdq_req_t r);
		bdq_rsp_t   o;
		logic [7:0] ring;
		o = '0;
		o.status = ST_OK;
		case (r.cmd)
			CMD_PUSH_FRONT: begin
				if (mirror_count == DEPTH) begin
					o.status = ST_FULL;
				end else begin
					// front moves back one slot, wrapping below zero
					mirror_head = mirror_head - 8'd1;
					mirror_slot[mirror_head] = r.item_in;
					mirror_count = mirror_count + 9'd1;
					// cursor stays on the same item, so its distance grows
					if (mirror_cur_live)
						mirror_cur_ofs = mirror_cur_ofs + 9'd1;
				end
			end
			CMD_PUSH_BACK: begin
				if (mirror_count == DEPTH) begin
					o.status = ST_FULL;
				end else begin
					ring = mirror_head + mirror_count[7:0];
					mirror_slot[ring] = r.item_in;
					mirror_count = mirror_count + 9'd1;
				end
			end
			CMD_POP_FRONT: begin
				if (mirror_count == 0) begin
					o.status = ST_EMPTY;
				end else begin
					o.item_out = mirror_slot[mirror_head];
					mirror_head = mirror_head + 8'd1;
					mirror_count = mirror_count - 9'd1;
					// a cursor on the popped item lands on the new front
					if (mirror_cur_live) begin
						if (mirror_cur_ofs > 0)
							mirror_cur_ofs = mirror_cur_ofs - 9'd1;
						if (mirror_count == 0) begin
							mirror_cur_live = 1'b0;
							mirror_cur_ofs = '0;
						end
					end
				end
			end
			CMD_READ_AT: begin
				if (r.position >= mirror_count) begin
					o.status = ST_RANGE;
				end else begin
					ring = mirror_head + r.position;
					o.item_out = mirror_slot[ring];
					// cursor parks on the item just read
					mirror_cur_ofs = {1'b0, r.position};
					mirror_cur_live = 1'b1;
				end
			end
			CMD_REWIND: begin
				mirror_cur_ofs = '0;
				mirror_cur_live = (mirror_count != 0);
			end
			CMD_READ_NEXT: begin
				if (!mirror_cur_live || mirror_cur_ofs >= mirror_count) begin
					mirror_cur_live = 1'b0;
					o.status = ST_END;
				end else begin
					ring = mirror_head + mirror_cur_ofs[7:0];
					o.item_out = mirror_slot[ring];
					mirror_cur_ofs = mirror_cur_ofs + 9'd1;
					// stepping past the last item leaves the cursor null
					if (mirror_cur_ofs >= mirror_count)
						mirror_cur_live = 1'b0;
				end
			end
			default: begin
			end
		endcase
		o.count = mirror_count;
		return o;
	endfunction

	function automatic stim_row_t mk_row(input logic [2:0] cmd, input logic [31:0] item,
			input logic [7:0] pos, input logic pinned, input logic [31:0] item_out,
			input bdq_status_t status, input logic [8:0] count);
		stim_row_t s;
		s.req.cmd = cmd;
		s.req.item_in = item;
		s.req.position = pos;
		s.pinned = pinned;
		s.want.item_out = item_out;
		s.want.status = status;
		s.want.count = count;
		return s;
	endfunction

	// command mix leans on pushes while filling and on pops while draining
	function automatic logic [2:0] pick_cmd(input logic filling);
		int roll;
		roll = $urandom_range(99);
		if (filling) begin
			if (roll < 40) return CMD_PUSH_FRONT;
			if (roll < 85) return CMD_PUSH_BACK;
			if (roll < 88) return CMD_POP_FRONT;
			if (roll < 93) return CMD_READ_AT;
			if (roll < 95) return CMD_REWIND;
			if (roll < 99) return CMD_READ_NEXT;
		end else begin
			if (roll < 4)  return CMD_PUSH_FRONT;
			if (roll < 8)  return CMD_PUSH_BACK;
			if (roll < 86) return CMD_POP_FRONT;
			if (roll < 92) return CMD_READ_AT;
			if (roll < 94) return CMD_REWIND;
			if (roll < 99) return CMD_READ_NEXT;
		end
		return ($urandom_range(1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
	endfunction

	// offer one item, with a random hold-off first, and wait until it is taken
	task automatic issue_command(input bdq_req_t r, input logic pinned, input bdq_rsp_t want);
		bdq_rsp_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// taken at this edge; the mirror always advances, pinned rows keep their own answer
		predicted = deque_outcome(r);
		awaited_results.push_back(pinned ? want : predicted);
	endtask

	// result side: done is a one-cycle strobe, compare against the oldest prediction
	always @(posedge clk) begin
		bdq_rsp_t exp_rsp;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %h", $time, rsp);
				fault_count++;
			end else begin
				exp_rsp = awaited_results.pop_front();
				if (rsp.item_out !== exp_rsp.item_out) begin
					$display("%0t item_out mismatch: expected %h, actual %h",
						$time, exp_rsp.item_out, rsp.item_out);
					fault_count++;
				end
				if (rsp.status !== exp_rsp.status) begin
					$display("%0t status mismatch: expected %0d, actual %0d",
						$time, exp_rsp.status, rsp.status);
					fault_count++;
				end
				if (rsp.count !== exp_rsp.count) begin
					$display("%0t count mismatch: expected %0d, actual %0d",
						$time, exp_rsp.count, rsp.count);
					fault_count++;
				end
			end
		end
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("bounded_deque_with_cursor_unit test failed");
		$finish;
	end

	initial begin
		bdq_req_t r;
		bdq_rsp_t none;
		logic     filling;
		none = '0;
		filling = 1'b1;

		// empty store: every read or pop reports its error, rewind leaves the cursor null
		plan[0]  = mk_row(CMD_POP_FRONT,  32'h0,        8'h00, 1'b1, 32'h0, ST_EMPTY, 9'd0);
		plan[1]  = mk_row(CMD_READ_AT,    32'h0,        8'h00, 1'b1, 32'h0, ST_RANGE, 9'd0);
		plan[2]  = mk_row(CMD_READ_NEXT,  32'h0,        8'h00, 1'b1, 32'h0, ST_END,   9'd0);
		plan[3]  = mk_row(CMD_REWIND,     32'h0,        8'h00, 1'b1, 32'h0, ST_OK,    9'd0);
		plan[4]  = mk_row(CMD_READ_NEXT,  32'h0,        8'h00, 1'b1, 32'h0, ST_END,   9'd0);
		// push back onto an empty store, then push front wraps the head below zero
		plan[5]  = mk_row(CMD_PUSH_BACK,  32'hffffffff, 8'h00, 1'b1, 32'h0, ST_OK,    9'd1);
		plan[6]  = mk_row(CMD_PUSH_FRONT, 32'h00000000, 8'h00, 1'b1, 32'h0, ST_OK,    9'd2);
		plan[7]  = mk_row(CMD_PUSH_FRONT, 32'h5a5a5a5a, 8'h00, 1'b1, 32'h0, ST_OK,    9'd3);
		// index past the items, at the far extreme and just beyond
		plan[8]  = mk_row(CMD_READ_AT,    32'h0,        8'hff, 1'b1, 32'h0, ST_RANGE, 9'd3);
		plan[9]  = mk_row(CMD_READ_AT,    32'h0,        8'h03, 1'b1, 32'h0, ST_RANGE, 9'd3);
		// read the last item, read next repeats it, then the cursor falls off the end
		plan[10] = mk_row(CMD_READ_AT,    32'h0,        8'h02, 1'b1, 32'hffffffff, ST_OK, 9'd3);
		plan[11] = mk_row(CMD_READ_NEXT,  32'h0,        8'h00, 1'b0, 32'h0, ST_OK,    9'd0);
		plan[12] = mk_row(CMD_READ_NEXT,  32'h0,        8'h00, 1'b1, 32'h0, ST_END,   9'd3);
		// push back must not bring a null cursor back
		plan[13] = mk_row(CMD_PUSH_BACK,  32'h12345678, 8'h00, 1'b1, 32'h0, ST_OK,    9'd4);
		plan[14] = mk_row(CMD_READ_NEXT,  32'h0,        8'h00, 1'b1, 32'h0, ST_END,   9'd4);
		plan[15] = mk_row(CMD_REWIND,     32'h0,        8'h00, 1'b1, 32'h0, ST_OK,    9'd4);
		plan[16] = mk_row(CMD_READ_NEXT,  32'h0,        8'h00, 1'b0, 32'h0, ST_OK,    9'd0);
		// push front keeps the cursor on the same item
		plan[17] = mk_row(CMD_PUSH_FRONT, 32'ha5a5a5a5, 8'h00, 1'b1, 32'h0, ST_OK,    9'd5);
		plan[18] = mk_row(CMD_READ_NEXT,  32'h0,        8'h00, 1'b0, 32'h0, ST_OK,    9'd0);
		// unused codes with every payload bit set are ignored
		plan[19] = mk_row(CMD_SPARE_LO,   32'hffffffff, 8'hff, 1'b1, 32'h0, ST_OK,    9'd5);
		plan[20] = mk_row(CMD_SPARE_HI,   32'hffffffff, 8'hff, 1'b1, 32'h0, ST_OK,    9'd5);
		// park the cursor on the second item, then pop twice to take it out from under the cursor
		plan[21] = mk_row(CMD_READ_AT,    32'h0,        8'h01, 1'b0, 32'h0, ST_OK,    9'd0);
		plan[22] = mk_row(CMD_POP_FRONT,  32'h0,        8'h00, 1'b1, 32'ha5a5a5a5, ST_OK, 9'd4);
		plan[23] = mk_row(CMD_POP_FRONT,  32'h0,        8'h00, 1'b1, 32'h5a5a5a5a, ST_OK, 9'd3);
		plan[24] = mk_row(CMD_READ_NEXT,  32'h0,        8'h00, 1'b0, 32'h0, ST_OK,    9'd0);

		// reset held from time zero, released on an edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			issue_command(plan[i].req, plan[i].pinned, plan[i].want);

		// random part: fill to full, drain to empty, and round again;
		// the sender idles rarely, then often, then never
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n < RANDOM_ITEMS / 3)
				sender_idle_pct = 7;
			else if (n < 2 * RANDOM_ITEMS / 3)
				sender_idle_pct = 48;
			else
				sender_idle_pct = 0;

			// linger a few items at either extreme before turning round
			if (filling && mirror_count == DEPTH && $urandom_range(7) == 0)
				filling = 1'b0;
			else if (!filling && mirror_count == 0 && $urandom_range(7) == 0)
				filling = 1'b1;

			r.cmd = pick_cmd(filling);
			r.item_in = $urandom;
			r.position = 8'($urandom);
			// indexed reads mostly land on a stored item
			if (r.cmd == CMD_READ_AT && mirror_count != 0 && $urandom_range(9) < 8)
				r.position = 8'($urandom_range(int'(mirror_count) - 1));
			issue_command(r, 1'b0, none);
		end

		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		// then idle on so that a stray extra strobe still gets caught
		repeat (4) @(posedge clk);

		if (fault_count == 0)
			$display("bounded_deque_with_cursor_unit test passed");
		else
			$display("bounded_deque_with_cursor_unit test failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/bdq_pkg.sv
rtl/bdq_ctrl.sv
rtl/bdq_datapath.sv
rtl/bounded_deque_with_cursor_unit.sv
tb/bounded_deque_with_cursor_unit_test.sv
